// File: hw/rtl/strs_pkg.sv
// Shared types and constants for the segment tree range sum unit.
// Holds the field widths, operation codes, sequencer states and memory request struct.
// No dependencies.
package strs_pkg;

  localparam int POS_W      = 11;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;
  // Widest node address the unit supports (LEAVES up to 65536 gives 2^17 nodes).
  localparam int ADDR_MAX_W = 17;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UWALK,
    ST_QA,
    ST_QB,
    ST_QEND
  } seq_state_t;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
    logic [SUM_W-1:0]      wr_data;
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } result_t;

endpackage

// File: hw/rtl/strs_channels.sv
// Valid/ready channel interfaces for the segment tree range sum unit.
// Depends on strs_pkg for the field widths.
interface strs_in_if;
  import strs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] leaf_value;
  logic [POS_W-1:0]        range_start;
  logic [POS_W-1:0]        range_end;

  modport source (output valid, operation, position, leaf_value, range_start, range_end,
                  input ready);
  modport sink   (input valid, operation, position, leaf_value, range_start, range_end,
                  output ready);
endinterface

interface strs_out_if;
  import strs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

// File: hw/rtl/strs_mem.sv
// Node sum memory: one write port and one read port, read data registered.
// Depends on strs_pkg for the request struct and the sum width.
module strs_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                      clk,
  input  strs_pkg::mem_req_t        req,
  output logic [strs_pkg::SUM_W-1:0] rd_data
);
  import strs_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [SUM_W-1:0] mem_r [DEPTH];
  logic [SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr[ADDR_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/strs_seq.sv
// Sequencer for the segment tree: memory clear, leaf update walk and range query walk.
// Depends on strs_pkg and the strs_in_if channel interface.
module strs_seq #(
  parameter int LEAVES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  strs_in_if.sink                    in_ch,
  input  logic [strs_pkg::SUM_W-1:0] rd_data,
  output strs_pkg::mem_req_t         mem_req,
  output strs_pkg::result_t          res,
  input  logic                       res_ready
);
  import strs_pkg::*;

  localparam int LOG   = $clog2(LEAVES);
  localparam int SPAN  = 1 << LOG;
  localparam int IDX_W = LOG + 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] a_r, a_nxt;
  logic [CNT_W-1:0] b_r, b_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             add_r, add_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;

  logic [CMP_W-1:0] start_w, end_w, lo_w, hi_w, pos_w;
  logic             range_empty, pos_ok;
  logic [CNT_W-1:0] a_init, b_init;
  logic [IDX_W-1:0] leaf_idx, parent_idx;
  logic [SUM_W-1:0] leaf_sext, acc_base, walk_sum;
  logic [CNT_W-1:0] b_dec;

  // Clip the query bounds to the leaf row and map them onto node indexes.
  always_comb begin
    start_w     = CMP_W'(in_ch.range_start);
    end_w       = CMP_W'(in_ch.range_end);
    pos_w       = CMP_W'(in_ch.position);
    lo_w        = (start_w == '0) ? CMP_W'(1) : start_w;
    hi_w        = (end_w > CMP_W'(LEAVES + 1)) ? CMP_W'(LEAVES + 1) : end_w;
    range_empty = (lo_w >= hi_w);
    a_init      = range_empty ? '0 : CNT_W'(lo_w - CMP_W'(1) + CMP_W'(SPAN));
    b_init      = range_empty ? '0 : CNT_W'(hi_w - CMP_W'(1) + CMP_W'(SPAN));
    pos_ok      = (pos_w != '0) && (pos_w <= CMP_W'(LEAVES));
    leaf_idx    = IDX_W'(pos_w - CMP_W'(1) + CMP_W'(SPAN));
    leaf_sext   = {{(SUM_W - VAL_W){in_ch.leaf_value[VAL_W-1]}}, in_ch.leaf_value};
    parent_idx  = IDX_W'(a_r >> 1);
    walk_sum    = acc_r + rd_data;
    acc_base    = acc_r + (add_r ? rd_data : '0);
    b_dec       = b_r - CNT_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_QUERY) begin
            state_nxt = ST_QA;
          end else if (pos_ok) begin
            state_nxt = ST_UWALK;
          end
        end
      end
      ST_UWALK: begin
        if (parent_idx == IDX_W'(1)) state_nxt = ST_IDLE;
      end
      ST_QA: begin
        state_nxt = (a_r < b_r) ? ST_QB : ST_QEND;
      end
      ST_QB: begin
        state_nxt = ST_QA;
      end
      ST_QEND: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    a_nxt       = a_r;
    b_nxt       = b_r;
    acc_nxt     = acc_r;
    add_nxt     = 1'b0;
    clr_nxt     = clr_r;
    mem_req     = '0;
    res.valid   = 1'b0;
    res.sum     = acc_r;
    in_ch.ready = (state_r == ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ADDR_MAX_W'(clr_r);
        clr_nxt         = clr_r + IDX_W'(1);
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_QUERY) begin
            a_nxt   = a_init;
            b_nxt   = b_init;
            acc_nxt = '0;
          end else if (pos_ok) begin
            // Write the leaf and fetch its sibling in the same cycle.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_MAX_W'(leaf_idx);
            mem_req.wr_data = leaf_sext;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ADDR_MAX_W'(leaf_idx ^ IDX_W'(1));
            a_nxt           = CNT_W'(leaf_idx);
            acc_nxt         = leaf_sext;
          end
        end
      end
      ST_UWALK: begin
        // The running node value plus its sibling gives the parent; the parent's
        // sibling is fetched while the parent is written.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ADDR_MAX_W'(parent_idx);
        mem_req.wr_data = walk_sum;
        mem_req.rd_en   = (parent_idx != IDX_W'(1));
        mem_req.rd_addr = ADDR_MAX_W'(parent_idx ^ IDX_W'(1));
        acc_nxt         = walk_sum;
        a_nxt           = CNT_W'(parent_idx);
      end
      ST_QA: begin
        acc_nxt = acc_base;
        if ((a_r < b_r) && a_r[0]) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_MAX_W'(a_r[IDX_W-1:0]);
          add_nxt         = 1'b1;
          a_nxt           = a_r + CNT_W'(1);
        end
      end
      ST_QB: begin
        acc_nxt = acc_base;
        a_nxt   = a_r >> 1;
        if (b_r[0]) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_MAX_W'(b_dec[IDX_W-1:0]);
          add_nxt         = 1'b1;
          b_nxt           = b_dec >> 1;
        end else begin
          b_nxt = b_r >> 1;
        end
      end
      ST_QEND: begin
        res.valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      add_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      add_r   <= add_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// File: hw/rtl/segment_tree_range_sum_unit.sv
// Segment tree range sum unit: point update and half-open range sum over LEAVES values.
// After reset all 2*SPAN node memory words (2048 at the default size) are cleared,
// SPAN being LEAVES rounded up to a power of two; no item is accepted during that pass.
// An update writes the leaf, then walks up one tree level per cycle to the root. A query
// reads up to two nodes per level, in ST_QA and ST_QB, through the single memory read
// port, then waits in ST_QEND for the output slot. One item is processed at a time.
module segment_tree_range_sum_unit #(
  parameter int LEAVES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  strs_in_if.sink   in_ch,
  strs_out_if.source out_ch
);
  import strs_pkg::*;

  localparam int ADDR_W = $clog2(LEAVES) + 1;

  mem_req_t         mem_req;
  logic [SUM_W-1:0] rd_data;
  result_t          res;
  logic             res_ready;

  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;

  strs_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  strs_seq #(.LEAVES(LEAVES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: the result slot frees when empty or when it is being taken.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_sum_r <= res.sum;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_sum = out_sum_r;

endmodule
